// ===== sv/received_range_tracker_core_defines.svh =====
// Assertion macros used by the received range tracker merge engine.
`ifndef RECEIVED_RANGE_TRACKER_CORE_DEFINES_SVH
`define RECEIVED_RANGE_TRACKER_CORE_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RRT_CHECK(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define RRT_CHECK_NEXT(name, trig, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) else $error(msg);

`endif

// ===== sv/rrt_pkg.sv =====
// Shared types for the received range tracker.
package rrt_pkg;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_SIZE  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         empty_range;
   } cmd_ctl_type;

   localparam int CTL_BITS = $bits(cmd_ctl_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_FLUSH,
      ST_COMMIT,
      ST_REPORT
   } eng_state_type;

endpackage

// ===== sv/rrt_front.sv =====
// Request intake: decodes the request kind and checks the range before queuing.
module rrt_front #(
   parameter int OFFSET_BITS = 48,
   parameter int IN_TW       = 144
) (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_tuser,
   input  logic [IN_TW-1:0]              req_tdata,
   input  logic                          q_ready,
   output logic                          q_push,
   output rrt_pkg::cmd_ctl_type          q_ctl,
   output logic [OFFSET_BITS-1:0]        q_start,
   output logic [OFFSET_BITS-1:0]        q_end,
   output logic [OFFSET_BITS-1:0]        q_size
);
   import rrt_pkg::*;

   always_comb begin
      q_start = req_tdata[OFFSET_BITS-1:0];
      q_end   = req_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
      q_size  = req_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS];
      unique case (req_tuser)
         CMD_ADD:   q_ctl.kind = CMD_ADD;
         CMD_SIZE:  q_ctl.kind = CMD_SIZE;
         CMD_CLEAR: q_ctl.kind = CMD_CLEAR;
         default:   q_ctl.kind = CMD_NOP;
      endcase
      q_ctl.empty_range = (q_end <= q_start);
   end

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

endmodule

// ===== sv/rrt_queue.sv =====
// Two-entry queue between request intake and the merge engine.
module rrt_queue #(
   parameter int WIDTH = 146
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             not_full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_full  = (fill_ff != 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

// ===== sv/rrt_engine.sv =====
// Merge engine: walks the sorted interval table and rebuilds it into the spare bank.
`include "received_range_tracker_core_defines.svh"

module rrt_engine #(
   parameter int MAX_INTERVALS = 16,
   parameter int OFFSET_BITS   = 48,
   parameter int CW            = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  rrt_pkg::cmd_ctl_type   q_ctl,
   input  logic [OFFSET_BITS-1:0] q_start,
   input  logic [OFFSET_BITS-1:0] q_end,
   input  logic [OFFSET_BITS-1:0] q_size,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   out_complete,
   output logic [CW-1:0]          out_count,
   output logic [OFFSET_BITS-1:0] out_size,
   output logic                   out_full
);
   import rrt_pkg::*;

   localparam int IW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int AW    = IW + 1;
   localparam int DEPTH = 2 * (2 ** IW);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

   logic [OFFSET_BITS-1:0] st_mem [DEPTH];
   logic [OFFSET_BITS-1:0] en_mem [DEPTH];

   eng_state_type          state_ff, state_in;
   logic                   bank_ff, bank_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [CW-1:0]          i_ff, i_in;
   logic [CW-1:0]          j_ff, j_in;
   logic [OFFSET_BITS-1:0] size_ff, size_in;
   logic                   pend_ff, pend_in;
   logic                   merged_ff, merged_in;
   logic                   drop_ff, drop_in;
   logic                   valid_ff, valid_in;
   logic [OFFSET_BITS-1:0] s_ff, s_in;
   logic [OFFSET_BITS-1:0] e_ff, e_in;
   logic [OFFSET_BITS-1:0] ns_ff, ns_in;
   logic [OFFSET_BITS-1:0] ne_ff, ne_in;
   logic [OFFSET_BITS-1:0] first_s_ff, first_s_in;
   logic [OFFSET_BITS-1:0] first_e_ff, first_e_in;
   logic [OFFSET_BITS-1:0] nf_s_ff, nf_s_in;
   logic [OFFSET_BITS-1:0] nf_e_ff, nf_e_in;
   logic                   oc_ff, oc_in;
   logic [CW-1:0]          ocnt_ff, ocnt_in;
   logic [OFFSET_BITS-1:0] osize_ff, osize_in;
   logic                   ofull_ff, ofull_in;
   logic [OFFSET_BITS-1:0] rd_s_ff, rd_e_ff;

   logic                   wr_en;
   logic [OFFSET_BITS-1:0] wr_s, wr_e;
   logic                   emit;
   logic [OFFSET_BITS-1:0] em_s, em_e;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic                   out_free;

   assign rd_addr  = {bank_ff, i_ff[IW-1:0]};
   assign wr_addr  = {~bank_ff, j_ff[IW-1:0]};
   assign out_free = !valid_ff || out_ready;

   always_comb begin
      state_in   = state_ff;
      bank_in    = bank_ff;
      cnt_in     = cnt_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      size_in    = size_ff;
      pend_in    = pend_ff;
      merged_in  = merged_ff;
      drop_in    = drop_ff;
      s_in       = s_ff;
      e_in       = e_ff;
      ns_in      = ns_ff;
      ne_in      = ne_ff;
      first_s_in = first_s_ff;
      first_e_in = first_e_ff;
      oc_in      = oc_ff;
      ocnt_in    = ocnt_ff;
      osize_in   = osize_ff;
      ofull_in   = ofull_ff;
      valid_in   = valid_ff && !out_ready;
      q_pop      = 1'b0;
      emit       = 1'b0;
      em_s       = ns_ff;
      em_e       = ne_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               s_in    = q_start;
               e_in    = q_end;
               drop_in = 1'b0;
               state_in = ST_REPORT;
               unique case (q_ctl.kind)
                  CMD_ADD: begin
                     if (q_end > size_ff) begin
                        size_in = q_end;
                     end
                     if (!q_ctl.empty_range) begin
                        i_in      = '0;
                        j_in      = '0;
                        pend_in   = 1'b1;
                        merged_in = 1'b0;
                        ns_in     = q_start;
                        ne_in     = q_end;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_SIZE: begin
                     if (q_size > size_ff) begin
                        size_in = q_size;
                     end
                  end
                  CMD_CLEAR: begin
                     cnt_in  = '0;
                     size_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = (i_ff == cnt_ff) ? ST_FLUSH : ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_READ;
            if (rd_e_ff < s_ff) begin
               emit = 1'b1;
               em_s = rd_s_ff;
               em_e = rd_e_ff;
               i_in = i_ff + 1'b1;
            end else if (pend_ff && rd_s_ff <= e_ff) begin
               ns_in     = (rd_s_ff < ns_ff) ? rd_s_ff : ns_ff;
               ne_in     = (rd_e_ff > ne_ff) ? rd_e_ff : ne_ff;
               merged_in = 1'b1;
               i_in      = i_ff + 1'b1;
            end else if (pend_ff) begin
               emit    = 1'b1;
               pend_in = 1'b0;
            end else begin
               emit = 1'b1;
               em_s = rd_s_ff;
               em_e = rd_e_ff;
               i_in = i_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            emit     = pend_ff;
            pend_in  = 1'b0;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!merged_ff && cnt_ff == MAX_CNT) begin
               drop_in = 1'b1;
            end else begin
               bank_in    = ~bank_ff;
               cnt_in     = j_ff;
               first_s_in = nf_s_ff;
               first_e_in = nf_e_ff;
            end
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               valid_in = 1'b1;
               oc_in    = (cnt_ff == CW'(1)) && (first_s_ff == '0) &&
                          (first_e_ff == size_ff);
               ocnt_in  = cnt_ff;
               osize_in = size_ff;
               ofull_in = drop_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      wr_en   = emit && (j_ff < MAX_CNT);
      wr_s    = em_s;
      wr_e    = em_e;
      nf_s_in = nf_s_ff;
      nf_e_in = nf_e_ff;
      if (emit) begin
         j_in = j_ff + 1'b1;
         if (j_ff == '0) begin
            nf_s_in = em_s;
            nf_e_in = em_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bank_ff  <= 1'b0;
         cnt_ff   <= '0;
         size_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bank_ff  <= bank_in;
         cnt_ff   <= cnt_in;
         size_ff  <= size_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      pend_ff    <= pend_in;
      merged_ff  <= merged_in;
      drop_ff    <= drop_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      ns_ff      <= ns_in;
      ne_ff      <= ne_in;
      first_s_ff <= first_s_in;
      first_e_ff <= first_e_in;
      nf_s_ff    <= nf_s_in;
      nf_e_ff    <= nf_e_in;
      oc_ff      <= oc_in;
      ocnt_ff    <= ocnt_in;
      osize_ff   <= osize_in;
      ofull_ff   <= ofull_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         st_mem[wr_addr] <= wr_s;
         en_mem[wr_addr] <= wr_e;
      end
      rd_s_ff <= st_mem[rd_addr];
      rd_e_ff <= en_mem[rd_addr];
   end

   assign out_valid    = valid_ff;
   assign out_complete = oc_ff;
   assign out_count    = ocnt_ff;
   assign out_size     = osize_ff;
   assign out_full     = ofull_ff;

   `RRT_CHECK(a_count_bound, cnt_ff <= MAX_CNT, "interval count exceeds table size")
   `RRT_CHECK_NEXT(a_read_to_eval, state_ff == ST_READ && i_ff != cnt_ff, state_ff == ST_EVAL, "walk did not evaluate a read entry")
   `RRT_CHECK_NEXT(a_commit_report, state_ff == ST_COMMIT, state_ff == ST_REPORT, "commit not followed by report")

endmodule

// ===== sv/received_range_tracker_core.sv =====
// Received range tracker top level: intake, request queue and merge engine.
// Size, clear and empty-range requests go from idle straight to report; an add walks
// the N held intervals through read and evaluate states on the registered memory, one
// more pass when the new range goes ahead of a held interval, then flushes, commits and reports.
// Throughput: one request at a time in the engine, two more may wait queued.
// Reset clears the interval count, known size, queue and output valid at once.
module received_range_tracker_core #(
   parameter int MAX_INTERVALS = 16,
   parameter int OFFSET_BITS   = 48,
   localparam int CW           = $clog2(MAX_INTERVALS + 1),
   localparam int IN_TW        = ((3 * OFFSET_BITS + 7) / 8) * 8,
   localparam int OUT_TW       = ((OFFSET_BITS + CW + 2 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,  // req_type
   input  logic [IN_TW-1:0]  req_tdata,  // start offset, end offset, declared size
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_TW-1:0] rsp_tdata   // complete, interval_count, known_size, table_full
);
   import rrt_pkg::*;

   localparam int QW = CTL_BITS + 3 * OFFSET_BITS;

   logic                   q_ready, q_push, q_valid, q_pop;
   cmd_ctl_type            f_ctl, e_ctl;
   logic [OFFSET_BITS-1:0] f_start, f_end, f_size;
   logic [OFFSET_BITS-1:0] e_start, e_end, e_size;
   logic [QW-1:0]          q_out;
   logic                   o_complete, o_full;
   logic [CW-1:0]          o_count;
   logic [OFFSET_BITS-1:0] o_size;

   rrt_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .IN_TW      (IN_TW)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .q_ready   (q_ready),
      .q_push    (q_push),
      .q_ctl     (f_ctl),
      .q_start   (f_start),
      .q_end     (f_end),
      .q_size    (f_size)
   );

   rrt_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data({f_ctl, f_size, f_end, f_start}),
      .not_full (q_ready),
      .pop      (q_pop),
      .not_empty(q_valid),
      .pop_data (q_out)
   );

   assign e_start = q_out[OFFSET_BITS-1:0];
   assign e_end   = q_out[2*OFFSET_BITS-1:OFFSET_BITS];
   assign e_size  = q_out[3*OFFSET_BITS-1:2*OFFSET_BITS];
   assign e_ctl   = cmd_ctl_type'(q_out[QW-1:3*OFFSET_BITS]);

   rrt_engine #(
      .MAX_INTERVALS(MAX_INTERVALS),
      .OFFSET_BITS  (OFFSET_BITS),
      .CW           (CW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_ctl       (e_ctl),
      .q_start     (e_start),
      .q_end       (e_end),
      .q_size      (e_size),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_complete(o_complete),
      .out_count   (o_count),
      .out_size    (o_size),
      .out_full    (o_full)
   );

   assign rsp_tdata = OUT_TW'({o_full, o_size, o_count, o_complete});

endmodule
